// ===== design/sfr_pkg.sv =====
// shared types and constants of the stream find-and-replace block
package sfr_pkg;

    localparam int PATTERN_MAX_DEFAULT     = 8;
    localparam int REPLACEMENT_MAX_DEFAULT = 8;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 4'd3;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;

    // source of the next result byte
    typedef enum logic [1:0] {
        SEL_FRONT,
        SEL_TAIL,
        SEL_REPL
    } emit_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      append;
        logic      emit;
        logic      last;
        emit_sel_t sel;
        logic      shift;
        logic      clear_count;
        logic      idx_clr;
        logic      idx_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_ge_plen;
        logic full_match;
        logic prefix_now;
        logic scan_last;
        logic repl_last;
        logic rlen_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/sfr_ctrl.sv =====
// controller state machine of the stream find-and-replace block
module sfr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    output logic                in_stall,
    input  sfr_pkg::dp_status_t status,
    output sfr_pkg::dp_cmd_t    cmd
);
    import sfr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_REPL  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd.load_in     = 1'b0;
        cmd.append      = 1'b0;
        cmd.emit        = 1'b0;
        cmd.last        = 1'b0;
        cmd.sel         = SEL_FRONT;
        cmd.shift       = 1'b0;
        cmd.clear_count = 1'b0;
        cmd.idx_clr     = 1'b0;
        cmd.idx_inc     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    // a text byte joins the held bytes unless they already fill the pattern
                    if (!in_kind && !status.count_ge_plen)
                    begin
                        cmd.append = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.count_zero)
                    begin
                        cmd.sel    = SEL_TAIL;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.sel   = SEL_FRONT;
                        cmd.shift = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.full_match)
                begin
                    cmd.clear_count = 1'b1;
                    cmd.idx_clr     = 1'b1;
                    state_next      = status.rlen_zero ? ST_IDLE : ST_REPL;
                end
                else if (status.count_zero || status.prefix_now)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.sel   = SEL_FRONT;
                    cmd.shift = 1'b1;
                    cmd.last  = status.scan_last;
                    if (status.scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REPL:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = SEL_REPL;
                    cmd.idx_inc = 1'b1;
                    cmd.last    = status.repl_last;
                    if (status.repl_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/sfr_dp.sv =====
// datapath: configuration registers, pending buffer, pattern compare and output register
module sfr_dp
#(
    parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEFAULT,
    parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_kind,
    input  logic [7:0]                       in_byte,
    input  sfr_pkg::dp_cmd_t                 cmd,
    output sfr_pkg::dp_status_t              status,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [7:0]                       out_byte,
    output logic                             out_last
);
    import sfr_pkg::*;

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = $clog2(REPLACEMENT_MAX + 1);

    function automatic logic [7:0] byte_of(input logic [63:0] word, input int i);
        byte_of = 8'(word >> (8 * i));
    endfunction

    logic [63:0]      pattern_reg;
    logic [3:0]       pattern_len_reg;
    logic [63:0]      repl_reg;
    logic [3:0]       repl_len_reg;
    logic [7:0]       buf_reg [PATTERN_MAX];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] repl_idx_reg;
    logic [IDX_W-1:0] repl_idx_next;
    logic [7:0]       tail_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] plen_eff;
    logic [IDX_W-1:0] rlen_eff;
    logic             prefix_now;
    logic             prefix_next;
    logic [7:0]       emit_byte;

    // effective lengths after clamping
    always_comb
    begin
        if (pattern_len_reg == 4'd0)
        begin
            plen_eff = CNT_W'(1);
        end
        else if (int'(pattern_len_reg) > PATTERN_MAX)
        begin
            plen_eff = CNT_W'(PATTERN_MAX);
        end
        else
        begin
            plen_eff = CNT_W'(pattern_len_reg);
        end
        if (int'(repl_len_reg) > REPLACEMENT_MAX)
        begin
            rlen_eff = IDX_W'(REPLACEMENT_MAX);
        end
        else
        begin
            rlen_eff = IDX_W'(repl_len_reg);
        end
    end

    // held bytes against the pattern, as they stand and after dropping the front byte
    always_comb
    begin
        prefix_now  = 1'b1;
        prefix_next = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (i < int'(count_reg) && buf_reg[i] != byte_of(pattern_reg, i))
            begin
                prefix_now = 1'b0;
            end
        end
        for (int i = 0; i < PATTERN_MAX - 1; i++)
        begin
            if (i + 1 < int'(count_reg) && buf_reg[i + 1] != byte_of(pattern_reg, i))
            begin
                prefix_next = 1'b0;
            end
        end
    end

    assign status.count_zero    = (count_reg == '0);
    assign status.count_ge_plen = (count_reg >= plen_eff);
    assign status.full_match    = (count_reg == plen_eff) && prefix_now;
    assign status.prefix_now    = prefix_now;
    assign status.scan_last     = (count_reg == CNT_W'(1)) || prefix_next;
    assign status.repl_last     = (int'(repl_idx_reg) + 1 == int'(rlen_eff));
    assign status.rlen_zero     = (rlen_eff == '0);
    assign status.out_free      = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (cmd.sel)
            SEL_FRONT: emit_byte = buf_reg[0];
            SEL_TAIL:  emit_byte = tail_reg;
            SEL_REPL:  emit_byte = byte_of(repl_reg, int'(repl_idx_reg));
            default:   emit_byte = tail_reg;
        endcase
    end

    always_comb
    begin
        priority if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        priority if (cmd.idx_clr)
        begin
            repl_idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            repl_idx_next = repl_idx_reg + IDX_W'(1);
        end
        else
        begin
            repl_idx_next = repl_idx_reg;
        end

        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            pattern_len_reg <= 4'd1;
            repl_reg        <= '0;
            repl_len_reg    <= '0;
            count_reg       <= '0;
            repl_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PATTERN_BYTES:      pattern_reg     <= cfg_data;
                    REG_PATTERN_LENGTH:     pattern_len_reg <= cfg_data[3:0];
                    REG_REPLACEMENT_BYTES:  repl_reg        <= cfg_data;
                    REG_REPLACEMENT_LENGTH: repl_len_reg    <= cfg_data[3:0];
                    default:                ;
                endcase
            end
            count_reg     <= count_next;
            repl_idx_reg  <= repl_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            tail_reg <= in_kind ? NEWLINE_CHAR : in_byte;
        end
        if (cmd.append)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (int'(count_reg) == i)
                begin
                    buf_reg[i] <= in_byte;
                end
            end
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < PATTERN_MAX - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
        if (cmd.emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== design/stream_find_and_replace.sv =====
// top level of the stream find-and-replace block
//
// Input channel (in_valid / in_stall, kind, text_byte): one text byte or an
// end-of-line mark per item. Output channel (out_valid / out_stall, out_byte,
// last): result bytes, last set on the final byte caused by one input item.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) sets the
// pattern, its length, the replacement and its length; write only while idle.
//
// One item at a time: the item is accepted, then its result bytes are loaded. A
// text byte that joins the held bytes and then completes a match or releases
// nothing passes through the scan state without loading a result byte. An item
// gives at most PATTERN_MAX result bytes after a flush or REPLACEMENT_MAX after a
// match; the single output register loads one byte a cycle unless the receiver
// stalls. The first result byte is loaded from the flush or scan state entered
// on the accept, or from the replacement state after a match.
// The next item is taken as soon as the last byte sits in the output register.
//
// A stalled receiver holds the output register and the controller waits.
// Reset empties the held bytes and loads the register reset values; no
// clearing pass is needed.
module stream_find_and_replace
#(
    parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEFAULT,
    parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [7:0]                      text_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic                            last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sfr_dp
    #(
        .PATTERN_MAX     (PATTERN_MAX),
        .REPLACEMENT_MAX (REPLACEMENT_MAX)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (kind),
        .in_byte   (text_byte),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .out_last  (last)
    );

    // an accepted item makes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // a result byte never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid && out_stall))
        else $error("output register overwritten under stall");

    // after the final byte of an item the block is ready again
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.last |=> !in_stall)
        else $error("block not ready after final result byte");

endmodule

// ===== bench/tb.sv =====
// testbench of the stream find-and-replace block: directed table, random text lines, checking
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 4'd15;

    localparam int USE_MODEL     = -1;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 30;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 44;
    localparam int HOLD_PHASE    = 4;
    localparam int PAUSE_PHASE   = 6;
    localparam int RANDOM_PAT_PHASE = 5;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_t;

    typedef struct {
        row_op_t         op;
        logic [3:0]      index;
        logic [63:0]     data;     // register value, or the text byte in 7:0
        logic            eol;
        int              n_typed;  // USE_MODEL: take the prediction
        logic [63:0]     typed;    // typed result bytes, first in 7:0
    } dir_row_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } result_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic                   kind      = 1'b0;
    logic [7:0]             text_byte = 8'h00;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             out_byte;
    logic                   last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    stream_find_and_replace u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .text_byte (text_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted block state
    logic [63:0] pat_word;
    logic [3:0]  pat_len_reg;
    logic [63:0] rep_word;
    logic [3:0]  rep_len_reg;
    logic [7:0]  held [8];
    int          held_n;

    result_t     expected_out [$];
    logic [7:0]  step_bytes [$];

    int fail_count       = 0;
    int items_sent       = 0;
    int results_seen     = 0;
    int settings_written = 0;
    bit offering         = 1'b0;
    bit cfg_open         = 1'b0;
    bit items_since_cfg  = 1'b0;
    bit snd_quiet        = 1'b0;
    bit rcv_quiet        = 1'b0;
    bit hold_long        = 1'b0;

    dir_row_t dir_table [$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("stream_find_and_replace: mismatch");
        $finish;
    end

    function automatic logic [7:0] byte_at(logic [63:0] w, int i);
        if (i >= 8)
            return 8'h00;
        return w[8*i +: 8];
    endfunction

    function automatic int pat_len_eff();
        int n;
        n = int'(pat_len_reg);
        if (n < 1)
            n = 1;
        if (n > 8)
            n = 8;
        return n;
    endfunction

    function automatic int rep_len_eff();
        int n;
        n = int'(rep_len_reg);
        if (n > 8)
            n = 8;
        return n;
    endfunction

    function automatic bit held_is_prefix(int n);
        for (int i = 0; i < n && i < 8; i++)
            if (held[i] !== byte_at(pat_word, i))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic dir_row_t item_row(logic k, logic [7:0] b, int n, logic [63:0] t);
        dir_row_t r;
        r.op      = ROW_ITEM;
        r.index   = '0;
        r.data    = {56'h0, b};
        r.eol     = k;
        r.n_typed = n;
        r.typed   = t;
        return r;
    endfunction

    function automatic dir_row_t write_row(logic [3:0] idx, logic [63:0] val);
        dir_row_t r;
        r.op      = ROW_WRITE;
        r.index   = idx;
        r.data    = val;
        r.eol     = KIND_TEXT;
        r.n_typed = 0;
        r.typed   = '0;
        return r;
    endfunction

    task automatic apply_reg(input logic [3:0] idx, input logic [63:0] val);
        unique case (idx)
            REG_PATTERN_BYTES:      pat_word    = val;
            REG_PATTERN_LENGTH:     pat_len_reg = val[3:0];
            REG_REPLACEMENT_BYTES:  rep_word    = val;
            REG_REPLACEMENT_LENGTH: rep_len_reg = val[3:0];
            default: ;
        endcase
    endtask

    task automatic push_results(input logic [7:0] bytes [$]);
        result_t r;
        for (int i = 0; i < bytes.size(); i++)
        begin
            r.ch  = bytes[i];
            r.fin = (i == bytes.size() - 1);
            expected_out.push_back(r);
        end
    endtask

    // find-and-replace on one item; bytes it releases land in step_bytes
    task automatic rewrite_item(input logic k, input logic [7:0] c);
        int plen;
        int rlen;
        step_bytes.delete();
        plen = pat_len_eff();
        if (k == KIND_EOL)
        begin
            for (int i = 0; i < held_n; i++)
                step_bytes.push_back(held[i]);
            held_n = 0;
            step_bytes.push_back(NEWLINE_CHAR);
        end
        else if (held_n >= plen)
        begin
            // pattern shortened under held bytes: flush, byte passes unmatched
            for (int i = 0; i < held_n; i++)
                step_bytes.push_back(held[i]);
            held_n = 0;
            step_bytes.push_back(c);
        end
        else
        begin
            held[held_n] = c;
            held_n++;
            if (held_n == plen && held_is_prefix(held_n))
            begin
                rlen = rep_len_eff();
                for (int i = 0; i < rlen; i++)
                    step_bytes.push_back(byte_at(rep_word, i));
                held_n = 0;
            end
            else
            begin
                while (held_n > 0 && !held_is_prefix(held_n))
                begin
                    step_bytes.push_back(held[0]);
                    for (int i = 1; i < held_n; i++)
                        held[i-1] = held[i];
                    held_n--;
                end
            end
        end
    endtask

    task automatic wait_drained();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
        if (items_since_cfg)
        begin
            // a held byte may still be in its compare cycle
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            items_since_cfg = 1'b0;
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_open = 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic send_item(input logic k, input logic [7:0] b, input bit use_model);
        int gap;
        if (cfg_open)
        begin
            cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        gap = snd_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        text_byte <= b;
        offering = 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        items_sent++;
        items_since_cfg = 1'b1;
        rewrite_item(k, b);
        if (use_model)
            push_results(step_bytes);
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] eb, input logic el);
        if (fail_count < 10)
            $display("%0t %s: expected byte %02h last %b, got byte %02h last %b",
                     $realtime, what, eb, el, out_byte, last);
        fail_count++;
    endtask

    initial
    begin : receiver
        int      n;
        result_t want;
        forever
        begin
            if (results_seen % 24 == 0)
                rcv_quiet = ($urandom_range(0, 3) == 0);
            if (hold_long)
            begin
                n = LONG_HOLD;
                hold_long = 1'b0;
            end
            else
                n = rcv_quiet ? 0 : $urandom_range(0, 14);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            results_seen++;
            if (expected_out.size() == 0)
                flag_mismatch("result with nothing expected", 8'hxx, 1'bx);
            else
            begin
                want = expected_out.pop_front();
                if (out_byte !== want.ch || last !== want.fin)
                    flag_mismatch("wrong result", want.ch, want.fin);
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t    row;
        logic [63:0] val;
        logic [63:0] pat;
        int          plen_raw;
        int          rlen_raw;
        int          plen;
        int          pick;
        int          cut;
        int          n0;
        bit          paused;
        result_t     r;

        pat_word    = '0;
        pat_len_reg = 4'd1;
        rep_word    = '0;
        rep_len_reg = 4'd0;
        held_n      = 0;
        for (int i = 0; i < 8; i++)
            held[i] = 8'h00;

        // after reset: pattern is one zero byte, replacement empty
        dir_table.push_back(item_row(KIND_TEXT, 8'hFF, 1, 64'hFF));
        dir_table.push_back(item_row(KIND_TEXT, 8'h00, 0, 64'h0));
        dir_table.push_back(item_row(KIND_EOL,  8'hAA, 1, 64'h0A));
        // "aab" -> "XY", with shifting on a false start
        dir_table.push_back(write_row(REG_PATTERN_BYTES,      64'h0000_0000_0062_6161));
        dir_table.push_back(write_row(REG_PATTERN_LENGTH,     64'd3));
        dir_table.push_back(write_row(REG_REPLACEMENT_BYTES,  64'h0000_0000_0000_5958));
        dir_table.push_back(write_row(REG_REPLACEMENT_LENGTH, 64'd2));
        dir_table.push_back(write_row(REG_UNUSED_LOW,         64'hFFFF_FFFF_FFFF_FFFF));
        dir_table.push_back(write_row(REG_UNUSED_TOP,         64'h5A5A_A5A5_0F0F_F0F0));
        dir_table.push_back(item_row(KIND_TEXT, 8'h61, USE_MODEL, '0));
        dir_table.push_back(item_row(KIND_TEXT, 8'h61, USE_MODEL, '0));
        dir_table.push_back(item_row(KIND_TEXT, 8'h61, USE_MODEL, '0));
        dir_table.push_back(item_row(KIND_TEXT, 8'h62, USE_MODEL, '0));
        dir_table.push_back(item_row(KIND_TEXT, 8'h61, USE_MODEL, '0));
        dir_table.push_back(item_row(KIND_EOL,  8'h00, USE_MODEL, '0));
        // zero pattern length acts as one, replacement length 15 acts as eight
        dir_table.push_back(write_row(REG_PATTERN_LENGTH,     64'd0));
        dir_table.push_back(write_row(REG_PATTERN_BYTES,      64'hFFFF_FFFF_FFFF_FFFF));
        dir_table.push_back(write_row(REG_REPLACEMENT_BYTES,  64'h807F_01FE_55AA_C33C));
        dir_table.push_back(write_row(REG_REPLACEMENT_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF));
        dir_table.push_back(item_row(KIND_TEXT, 8'hFF, 8, 64'h807F_01FE_55AA_C33C));
        dir_table.push_back(item_row(KIND_TEXT, 8'h7F, 1, 64'h7F));
        // pattern length 15 acts as eight; shorten it under five held bytes
        dir_table.push_back(write_row(REG_PATTERN_BYTES,      64'h6867_6665_6463_6261));
        dir_table.push_back(write_row(REG_PATTERN_LENGTH,     64'd15));
        for (int i = 0; i < 5; i++)
            dir_table.push_back(item_row(KIND_TEXT, 8'(8'h61 + i), USE_MODEL, '0));
        dir_table.push_back(write_row(REG_PATTERN_LENGTH,     64'd3));
        dir_table.push_back(item_row(KIND_TEXT, 8'h7A, 6, 64'h0000_7A65_6463_6261));
        // seven held bytes flushed by end of line
        dir_table.push_back(write_row(REG_PATTERN_LENGTH,     64'hFFFF_FFFF_FFFF_FFF8));
        for (int i = 0; i < 7; i++)
            dir_table.push_back(item_row(KIND_TEXT, 8'(8'h61 + i), USE_MODEL, '0));
        dir_table.push_back(item_row(KIND_EOL,  8'h55, 8, 64'h0A67_6665_6463_6261));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[j])
        begin
            row = dir_table[j];
            if (row.op == ROW_WRITE)
                write_reg(row.index, row.data);
            else
            begin
                send_item(row.eol, row.data[7:0], row.n_typed == USE_MODEL);
                for (int i = 0; i < row.n_typed; i++)
                begin
                    r.ch  = row.typed[8*i +: 8];
                    r.fin = (i == row.n_typed - 1);
                    expected_out.push_back(r);
                end
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            unique case (ph)
                0:
                begin
                    plen_raw = 1;
                    rlen_raw = 0;
                end
                1:
                begin
                    plen_raw = 8;
                    rlen_raw = 8;
                end
                2:
                begin
                    plen_raw = $urandom_range(9, 15);
                    rlen_raw = $urandom_range(9, 15);
                end
                3:
                begin
                    plen_raw = 0;
                    rlen_raw = $urandom_range(0, 8);
                end
                default:
                begin
                    plen_raw = $urandom_range(1, 4);
                    rlen_raw = $urandom_range(0, 8);
                end
            endcase
            if (ph == RANDOM_PAT_PHASE)
                pat = {$urandom, $urandom};
            else
                for (int i = 0; i < 8; i++)
                    pat[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 2));
            write_reg(REG_PATTERN_BYTES, pat);
            val = {$urandom, $urandom};
            write_reg(REG_PATTERN_LENGTH, {val[63:4], 4'(plen_raw)});
            write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            val = {$urandom, $urandom};
            write_reg(REG_REPLACEMENT_LENGTH, {val[63:4], 4'(rlen_raw)});
            write_reg(4'($urandom_range(4, 15)), {$urandom, $urandom});
            settings_written++;

            snd_quiet = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            if (ph == HOLD_PHASE)
                hold_long = 1'b1;
            paused = 1'b0;
            n0 = items_sent;
            while (items_sent - n0 < PHASE_ITEMS)
            begin
                plen = pat_len_eff();
                pick = $urandom_range(0, 9);
                if (pick < 3)
                begin
                    for (int i = 0; i < plen; i++)
                        send_item(KIND_TEXT, byte_at(pat_word, i), 1'b1);
                end
                else if (pick < 6)
                begin
                    // false start: part of the pattern, then something else
                    cut = $urandom_range(0, plen - 1);
                    for (int i = 0; i < cut; i++)
                        send_item(KIND_TEXT, byte_at(pat_word, i), 1'b1);
                    if (pick == 5)
                        send_item(KIND_EOL, 8'($urandom), 1'b1);
                    else
                        send_item(KIND_TEXT, byte_at(pat_word, $urandom_range(0, 7)), 1'b1);
                end
                else if (pick < 8)
                    send_item(KIND_TEXT, byte_at(pat_word, $urandom_range(0, 7)), 1'b1);
                else if (pick == 8)
                    send_item(KIND_TEXT, 8'($urandom_range(0, 255)), 1'b1);
                else
                    send_item(KIND_EOL, 8'($urandom), 1'b1);
                if (ph == PAUSE_PHASE && !paused && items_sent - n0 >= 20)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        if (cfg_open)
            cfg_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += expected_out.size();

        $display("covered %0d items and %0d result bytes over %0d random settings",
                 items_sent, results_seen, settings_written);
        $display("directed table plus line-shaped random text, %0d failures", fail_count);
        if (fail_count == 0)
            $display("stream_find_and_replace: match");
        else
            $display("stream_find_and_replace: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sfr_pkg.sv
design/sfr_ctrl.sv
design/sfr_dp.sv
design/stream_find_and_replace.sv
bench/tb.sv
